// File: sv/assert_macros.svh
// Assertion macros shared by the RTL of the character display formatter.
// Needs nothing else; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle during reset.
`define ASSERT_SAME(label, clock, rst_n, cond, expr) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (cond) |-> (expr)) \
		else $error("assertion failed");

// Next-cycle implication, idle during reset.
`define ASSERT_NEXT(label, clock, rst_n, cond, expr) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (cond) |=> (expr)) \
		else $error("assertion failed");

`endif

// File: sv/clnf_pkg.sv
// Types and constants shared by the character display formatter.
// Used by clnf_ctrl, clnf_datapath and char_lcd_number_formatter.
package clnf_pkg;

	// Request action codes
	localparam logic [2:0] ACT_INIT = 3'd0;
	localparam logic [2:0] ACT_CHAR = 3'd1;
	localparam logic [2:0] ACT_UDEC = 3'd2;
	localparam logic [2:0] ACT_SDEC = 3'd3;
	localparam logic [2:0] ACT_HEX  = 3'd4;
	localparam logic [2:0] ACT_BIN  = 3'd5;
	localparam logic [2:0] ACT_DATA = 3'd6;

	localparam logic [1:0] ROW_ONE = 2'd1;
	localparam logic [1:0] ROW_TWO = 2'd2;

	localparam logic RS_CMD  = 1'b0;
	localparam logic RS_DATA = 1'b1;

	localparam logic [7:0] SET_ADDR    = 8'h80;
	localparam logic [7:0] ROW_TWO_OFS = 8'h40;
	localparam logic [7:0] CHAR_PLUS   = 8'h2B;
	localparam logic [7:0] CHAR_MINUS  = 8'h2D;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_A_OFS  = 8'h37;

	localparam int IN_W  = 40;
	localparam int IDX_W = 4;
	// Decimal digits that a 16-bit magnitude can have
	localparam logic [IDX_W-1:0] DEC_DIGITS = 4'd5;
	localparam logic [IDX_W-1:0] INIT_LAST  = 4'd3;
	localparam logic [IDX_W-1:0] HEX_DIGITS = 4'd4;

	// Reciprocal of ten, scaled by 2^19; exact for any 16-bit dividend
	localparam logic [16:0] RECIP10 = 17'h0CCCD;

	typedef enum logic [2:0] {
		SRC_INIT,
		SRC_CURSOR,
		SRC_SIGN,
		SRC_CHAR,
		SRC_DIGIT
	} src_t;

	typedef struct packed {
		logic             load;
		logic             conv_step;
		logic             emit;
		src_t             src;
		logic [IDX_W-1:0] idx;
		logic             last;
	} cmd_t;

	typedef struct packed {
		logic             out_free;
		logic [2:0]       action;
		logic [1:0]       line;
		logic             cnt_zero;
		logic [IDX_W-1:0] top_idx;
	} status_t;

	function automatic logic [7:0] init_cmd(input logic [IDX_W-1:0] idx);
		logic [7:0] b;
		case (idx[1:0])
			2'd0:    b = 8'h38;
			2'd1:    b = 8'h0C;
			2'd2:    b = 8'h06;
			default: b = 8'h01;
		endcase
		return b;
	endfunction

endpackage

// File: sv/clnf_ctrl.sv
// Controller state machine of the character display formatter.
// Depends on clnf_pkg; drives clnf_datapath through cmd_t / status_t.
module clnf_ctrl import clnf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_CONV,
		ST_CURSOR,
		ST_SIGN,
		ST_CHAR,
		ST_INIT,
		ST_DIGITS
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;
	logic             fire;
	logic             row_ok;

	assign row_ok = (status.line == ROW_ONE) || (status.line == ROW_TWO);
	assign fire   = cmd.emit && status.out_free;

	always_comb begin
		s_tready      = 1'b0;
		cmd.load      = 1'b0;
		cmd.conv_step = 1'b0;
		cmd.emit      = 1'b0;
		cmd.src       = SRC_CHAR;
		cmd.idx       = idx_q;
		cmd.last      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_DISPATCH: ;
			ST_CONV: cmd.conv_step = 1'b1;
			ST_CURSOR: begin
				cmd.emit = row_ok;
				cmd.src  = SRC_CURSOR;
				cmd.last = !((status.action == ACT_CHAR) || (status.action == ACT_SDEC)
					|| !status.cnt_zero);
			end
			ST_SIGN: begin
				cmd.emit = 1'b1;
				cmd.src  = SRC_SIGN;
				cmd.last = status.cnt_zero;
			end
			ST_CHAR: begin
				cmd.emit = 1'b1;
				cmd.src  = SRC_CHAR;
				cmd.last = 1'b1;
			end
			ST_INIT: begin
				cmd.emit = 1'b1;
				cmd.src  = SRC_INIT;
				cmd.last = (idx_q == INIT_LAST);
			end
			ST_DIGITS: begin
				cmd.emit = 1'b1;
				cmd.src  = SRC_DIGIT;
				cmd.last = (idx_q == '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_DISPATCH;
				end
				ST_DISPATCH: begin
					idx_q <= '0;
					unique case (status.action) inside
						ACT_INIT:                   state_q <= ST_INIT;
						ACT_CHAR, ACT_HEX, ACT_BIN: state_q <= ST_CURSOR;
						ACT_UDEC, ACT_SDEC:         state_q <= ST_CONV;
						ACT_DATA:                   state_q <= ST_CHAR;
						default:                    state_q <= ST_IDLE;
					endcase
				end
				ST_CONV: begin
					if (idx_q == DEC_DIGITS - 4'd1) state_q <= ST_CURSOR;
					else idx_q <= idx_q + 4'd1;
				end
				ST_CURSOR: begin
					// skip the address write when the row is not one or two
					if (!cmd.emit || fire) begin
						unique case (status.action) inside
							ACT_CHAR: state_q <= ST_CHAR;
							ACT_SDEC: state_q <= ST_SIGN;
							default: begin
								idx_q   <= status.top_idx;
								state_q <= status.cnt_zero ? ST_IDLE : ST_DIGITS;
							end
						endcase
					end
				end
				ST_SIGN: begin
					if (fire) begin
						idx_q   <= status.top_idx;
						state_q <= status.cnt_zero ? ST_IDLE : ST_DIGITS;
					end
				end
				ST_CHAR: begin
					if (fire) state_q <= ST_IDLE;
				end
				ST_INIT: begin
					if (fire) begin
						if (idx_q == INIT_LAST) state_q <= ST_IDLE;
						else idx_q <= idx_q + 4'd1;
					end
				end
				ST_DIGITS: begin
					if (fire) begin
						if (idx_q == '0) state_q <= ST_IDLE;
						else idx_q <= idx_q - 4'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: sv/clnf_datapath.sv
// Datapath of the character display formatter: request capture, decimal
// conversion, byte selection and the output register. Depends on clnf_pkg.
module clnf_datapath import clnf_pkg::*; #(
	parameter int MAX_DIGITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [IN_W-1:0] s_tdata,
	input  cmd_t            cmd,
	output status_t         status,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata,
	output logic [0:0]      m_tuser,
	output logic            m_tlast
);

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);

	logic [2:0]       in_action;
	logic [1:0]       in_line;
	logic [4:0]       in_column;
	logic [15:0]      in_number;
	logic [4:0]       in_count;
	logic [7:0]       in_char;

	logic [2:0]       action_q;
	logic [1:0]       line_q;
	logic [4:0]       column_q;
	logic [15:0]      number_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       char_q;
	logic [15:0]      val_q;
	logic [3:0]       dec_q [5];

	logic [32:0]      prod;
	logic [12:0]      quot;
	logic [15:0]      quot10;
	logic [3:0]       rem;
	logic [3:0]       digit;
	logic [7:0]       cur_byte;
	logic [7:0]       byte_sel;
	logic             out_free;

	assign in_action = s_tdata[2:0];
	assign in_line   = s_tdata[4:3];
	assign in_column = s_tdata[9:5];
	assign in_number = s_tdata[25:10];
	assign in_count  = s_tdata[30:26];
	assign in_char   = s_tdata[38:31];

	// one decimal digit per step: quotient by reciprocal multiply
	assign prod   = val_q * RECIP10;
	assign quot   = prod[31:19];
	assign quot10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
	assign rem    = 4'(val_q - quot10);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= in_action;
			line_q   <= in_line;
			column_q <= in_column;
			number_q <= in_number;
			char_q   <= in_char;
			cnt_q    <= (in_count > 5'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : CNT_W'(in_count);
			// magnitude of a negative value for signed decimal
			val_q    <= (in_action == ACT_SDEC && in_number[15]) ? 16'(16'd0 - in_number)
				: in_number;
		end else if (cmd.conv_step) begin
			dec_q[cmd.idx[2:0]] <= rem;
			val_q <= {3'b000, quot};
		end
	end

	always_comb begin
		unique case (action_q) inside
			ACT_HEX: digit = (cmd.idx < HEX_DIGITS) ? number_q[{cmd.idx[1:0], 2'b00} +: 4] : 4'd0;
			ACT_BIN: digit = {3'b000, number_q[cmd.idx]};
			default: digit = (cmd.idx < DEC_DIGITS) ? dec_q[cmd.idx[2:0]] : 4'd0;
		endcase
	end

	always_comb begin
		if (line_q == ROW_TWO) cur_byte = SET_ADDR | (8'({3'b000, column_q}) - 8'd1 + ROW_TWO_OFS);
		else cur_byte = SET_ADDR | (8'({3'b000, column_q}) - 8'd1);
	end

	always_comb begin
		unique case (cmd.src)
			SRC_INIT:   byte_sel = init_cmd(cmd.idx);
			SRC_CURSOR: byte_sel = cur_byte;
			SRC_SIGN:   byte_sel = number_q[15] ? CHAR_MINUS : CHAR_PLUS;
			SRC_CHAR:   byte_sel = char_q;
			SRC_DIGIT:  byte_sel = (digit < 4'd10) ? CHAR_ZERO + {4'd0, digit}
				: CHAR_A_OFS + {4'd0, digit};
			default:    byte_sel = char_q;
		endcase
	end

	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit && out_free) begin
			m_tdata <= byte_sel;
			m_tuser <= ((cmd.src == SRC_INIT) || (cmd.src == SRC_CURSOR)) ? RS_CMD : RS_DATA;
			m_tlast <= cmd.last;
		end
	end

	assign status.out_free = out_free;
	assign status.action   = action_q;
	assign status.line     = line_q;
	assign status.cnt_zero = (cnt_q == '0);
	assign status.top_idx  = IDX_W'(cnt_q - CNT_W'(1));

endmodule

// File: sv/char_lcd_number_formatter.sv
// Channel  | dir | signals                      | contents
// s_*      | in  | tvalid, tready, tdata[39:0]  | one display request
// m_*      | out | tvalid, tready, tdata[7:0],  | one bus write to the panel,
//          |     | tuser[0:0], tlast            | tlast on the final write
// A request passes the accept state, the dispatch state, the decimal conversion
// steps for decimal actions, then its writes (up to 18); the address-write state
// is still passed when that write is skipped.
// The write sequencer in clnf_ctrl walks these states; a new request enters once
// it is done, while the last write may still sit in the output register.
// A stalled m_tready holds the sequencer. arst_n clears control state only.
// Top level; depends on clnf_pkg, clnf_ctrl, clnf_datapath, assert_macros.svh.
`include "assert_macros.svh"
module char_lcd_number_formatter import clnf_pkg::*; #(
	parameter int MAX_DIGITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	// action[2:0], line[4:3], column[9:5], number[25:10], digit_count[30:26],
	// char_code[38:31], zero[39]
	input  logic [IN_W-1:0] s_tdata,
	output logic            m_tvalid,
	input  logic            m_tready,
	// bus_byte[7:0]
	output logic [7:0]      m_tdata,
	// register_select[0]
	output logic [0:0]      m_tuser,
	output logic            m_tlast
);

	cmd_t    cmd;
	status_t status;

	clnf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	clnf_datapath #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.status   (status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	`ASSERT_NEXT(a_one_request, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`ASSERT_SAME(a_no_write_idle, clk, arst_n, cmd.emit, !s_tready)
	`ASSERT_NEXT(a_dispatch_quiet, clk, arst_n, s_tvalid && s_tready,
		!cmd.emit && !cmd.conv_step)

endmodule

// File: tb/clnf_write_checker.sv
// Checker for char_lcd_number_formatter: predicts the panel writes of every
// accepted request and compares them with the writes leaving the block.
// Depends on clnf_pkg for action codes, row codes and character constants.
module clnf_write_checker import clnf_pkg::*; #(
	parameter int MAX_DIGITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            s_tready,
	// action[2:0], line[4:3], column[9:5], number[25:10], digit_count[30:26],
	// char_code[38:31], zero[39]
	input  logic [IN_W-1:0] s_tdata,
	input  logic            m_tvalid,
	input  logic            m_tready,
	// bus_byte[7:0]
	input  logic [7:0]      m_tdata,
	// register_select[0]
	input  logic [0:0]      m_tuser,
	input  logic            m_tlast,
	output int              fail_count,
	output int              pending_writes
);

	localparam logic [7:0] LCD_FUNC_SET   = 8'h38;
	localparam logic [7:0] LCD_DISPLAY_ON = 8'h0C;
	localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
	localparam logic [7:0] LCD_CLEAR      = 8'h01;

	typedef struct packed {
		logic       pad;
		logic [7:0] char_code;
		logic [4:0] digit_count;
		logic [15:0] number;
		logic [4:0] column;
		logic [1:0] line;
		logic [2:0] action;
	} request_t;

	typedef struct packed {
		logic       rs;
		logic [7:0] bus_byte;
		logic       last;
	} lcd_write_t;

	lcd_write_t expected_writes[$];
	lcd_write_t head;

	task automatic report_mismatch(input string what, input int got, input int want);
		fail_count++;
		$display("ERROR: %s: got %0h, expected %0h", what, got, want);
	endtask

	function automatic void push_write(input logic rs, input logic [7:0] bus_byte);
		lcd_write_t w;
		w.rs = rs;
		w.bus_byte = bus_byte;
		w.last = 1'b0;
		expected_writes.push_back(w);
	endfunction

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		return (d < 4'd10) ? CHAR_ZERO + 8'(d) : CHAR_A_OFS + 8'(d);
	endfunction

	// Work out every write of one request and queue them in order.
	function automatic void queue_display_writes(input request_t req);
		int first;
		int digits;
		int base;
		int value;
		logic [3:0] digit_at [MAX_DIGITS];
		lcd_write_t tail;
		first = expected_writes.size();
		digits = (req.digit_count > MAX_DIGITS) ? MAX_DIGITS : int'(req.digit_count);
		value = int'(req.number);
		base = 0;
		case (req.action)
			ACT_INIT: begin
				push_write(RS_CMD, LCD_FUNC_SET);
				push_write(RS_CMD, LCD_DISPLAY_ON);
				push_write(RS_CMD, LCD_ENTRY_MODE);
				push_write(RS_CMD, LCD_CLEAR);
			end
			ACT_DATA: push_write(RS_DATA, req.char_code);
			ACT_CHAR, ACT_UDEC, ACT_SDEC, ACT_HEX, ACT_BIN: begin
				// address wraps at eight bits, column zero included
				if (req.line == ROW_ONE)
					push_write(RS_CMD, SET_ADDR | (8'(req.column) - 8'd1));
				else if (req.line == ROW_TWO)
					push_write(RS_CMD, SET_ADDR | (8'(req.column) - 8'd1 + ROW_TWO_OFS));
				case (req.action)
					ACT_CHAR: push_write(RS_DATA, req.char_code);
					ACT_UDEC: base = 10;
					ACT_SDEC: begin
						base = 10;
						if (req.number[15]) begin
							push_write(RS_DATA, CHAR_MINUS);
							value = 65536 - value;
						end else begin
							push_write(RS_DATA, CHAR_PLUS);
						end
					end
					ACT_HEX: base = 16;
					default: base = 2;
				endcase
			end
			default: ;
		endcase
		if (base != 0) begin
			for (int p = 0; p < MAX_DIGITS; p++) begin
				digit_at[p] = 4'(value % base);
				value = value / base;
			end
			for (int p = digits - 1; p >= 0; p--)
				push_write(RS_DATA, digit_char(digit_at[p]));
		end
		// mark the final write of the request, if it made any
		if (expected_writes.size() > first) begin
			tail = expected_writes.pop_back();
			tail.last = 1'b1;
			expected_writes.push_back(tail);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_writes.size() == 0) begin
					report_mismatch("write with none pending", int'(m_tdata), 0);
				end else begin
					head = expected_writes.pop_front();
					if (m_tuser[0] !== head.rs)
						report_mismatch("register_select", int'(m_tuser[0]), int'(head.rs));
					if (m_tdata !== head.bus_byte)
						report_mismatch("bus_byte", int'(m_tdata), int'(head.bus_byte));
					if (m_tlast !== head.last)
						report_mismatch("last", int'(m_tlast), int'(head.last));
				end
			end
			if (s_tvalid && s_tready)
				queue_display_writes(request_t'(s_tdata));
			pending_writes = expected_writes.size();
		end
	end

endmodule

// File: tb/tb_top.sv
// Top of the char_lcd_number_formatter testbench: clock, reset, request and
// ready stimulus with random gaps, watchdog and verdict.
// Depends on clnf_pkg, char_lcd_number_formatter and clnf_write_checker.
module tb_top;
	import clnf_pkg::*;

	localparam int         MAX_DIGITS   = 16;
	localparam int         RANDOM_ITEMS = 250;
	localparam int         IDLE_LIMIT   = 1000;
	localparam int         DRAIN_CYCLES = 50;
	localparam logic [2:0] ACT_UNUSED   = 3'd7;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            s_tvalid;
	logic            s_tready;
	logic [IN_W-1:0] s_tdata;
	logic            m_tvalid;
	logic            m_tready;
	logic [7:0]      m_tdata;
	logic [0:0]      m_tuser;
	logic            m_tlast;
	int              fail_count;
	int              pending_writes;
	int              stall_cycles;
	bit              sender_gaps_on;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	char_lcd_number_formatter #(
		.MAX_DIGITS(MAX_DIGITS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	clnf_write_checker #(
		.MAX_DIGITS(MAX_DIGITS)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.fail_count    (fail_count),
		.pending_writes(pending_writes)
	);

	// Mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic send_request(input logic [2:0] action, input logic [1:0] row,
			input logic [4:0] column, input logic [15:0] number,
			input logic [4:0] digit_count, input logic [7:0] char_code);
		int gap;
		s_tdata <= {1'b0, char_code, digit_count, number, column, row, action};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		gap = sender_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Receiver: runs of ready, broken by stalls; some long runs with no stall.
	initial begin : ready_driver
		int hold;
		int gap;
		forever begin
			hold = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 6);
			m_tready <= 1'b1;
			repeat (hold) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [2:0]  action;
		logic [1:0]  row;
		logic [4:0]  column;
		logic [15:0] number;
		logic [4:0]  digit_count;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		sender_gaps_on = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(ACT_INIT, 2'd0, 5'd0, 16'h0000, 5'd0, 8'h00);
		send_request(ACT_CHAR, ROW_ONE, 5'd1, 16'hFFFF, 5'd31, 8'h00);
		send_request(ACT_CHAR, ROW_TWO, 5'd16, 16'h0000, 5'd0, 8'hFF);
		send_request(ACT_UDEC, ROW_ONE, 5'd3, 16'hFFFF, 5'd5, 8'h00);
		send_request(ACT_UDEC, 2'd0, 5'd1, 16'h0000, 5'd16, 8'hFF);
		// empty request: no cursor command and no digits
		send_request(ACT_UDEC, 2'd3, 5'd5, 16'h1234, 5'd0, 8'h00);
		send_request(ACT_UDEC, ROW_ONE, 5'd7, 16'd12345, 5'd0, 8'h00);
		send_request(ACT_SDEC, ROW_TWO, 5'd2, 16'h8000, 5'd5, 8'h00);
		send_request(ACT_SDEC, ROW_ONE, 5'd9, 16'h7FFF, 5'd6, 8'h00);
		send_request(ACT_SDEC, ROW_TWO, 5'd4, 16'h0000, 5'd1, 8'h00);
		send_request(ACT_SDEC, 2'd3, 5'd1, 16'hFFFF, 5'd31, 8'h00);
		send_request(ACT_SDEC, ROW_ONE, 5'd1, 16'h0000, 5'd0, 8'h00);
		send_request(ACT_HEX, ROW_ONE, 5'd12, 16'hABCD, 5'd4, 8'h00);
		send_request(ACT_HEX, ROW_TWO, 5'd1, 16'h1234, 5'd16, 8'h00);
		send_request(ACT_BIN, ROW_ONE, 5'd1, 16'hFFFF, 5'd16, 8'h00);
		send_request(ACT_BIN, ROW_TWO, 5'd1, 16'h5555, 5'd17, 8'h00);
		send_request(ACT_DATA, ROW_ONE, 5'd1, 16'h0000, 5'd0, 8'hA5);
		send_request(ACT_DATA, 2'd0, 5'd31, 16'hFFFF, 5'd31, 8'h5A);
		send_request(ACT_UNUSED, ROW_ONE, 5'd1, 16'hFFFF, 5'd16, 8'hFF);
		// out-of-range columns: column zero wraps the address byte
		send_request(ACT_CHAR, ROW_ONE, 5'd0, 16'h0000, 5'd0, 8'h41);
		send_request(ACT_CHAR, ROW_TWO, 5'd0, 16'h0000, 5'd0, 8'h42);
		send_request(ACT_CHAR, ROW_TWO, 5'd31, 16'h0000, 5'd0, 8'h43);
		send_request(ACT_HEX, ROW_ONE, 5'd17, 16'hF00F, 5'd2, 8'h00);
		send_request(ACT_INIT, ROW_TWO, 5'd31, 16'hFFFF, 5'd31, 8'hFF);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// hold a stretch of back-to-back requests now and then
			sender_gaps_on = !((n % 60) >= 40);
			action = ($urandom_range(0, 39) == 0) ? ACT_UNUSED : 3'($urandom_range(0, 6));
			if ($urandom_range(0, 7) == 0)
				row = 2'($urandom_range(0, 3));
			else
				row = $urandom_range(0, 1) ? ROW_TWO : ROW_ONE;
			column = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
				: 5'($urandom_range(1, 16));
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 3))
					0: number = 16'h0000;
					1: number = 16'hFFFF;
					2: number = 16'h8000;
					default: number = 16'h7FFF;
				endcase
			end else begin
				number = 16'($urandom);
			end
			digit_count = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
				: 5'($urandom_range(0, 16));
			send_request(action, row, column, number, digit_count, 8'($urandom));
		end
		s_tvalid <= 1'b0;

		// let the last request reach the checker, then drain
		@(posedge clk);
		while (pending_writes != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_writes == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	// End the run once nothing has moved on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= IDLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule

// File: char_lcd_number_formatter.f
+incdir+sv
sv/clnf_pkg.sv
sv/clnf_ctrl.sv
sv/clnf_datapath.sv
sv/char_lcd_number_formatter.sv
tb/clnf_write_checker.sv
tb/tb_top.sv
